// ===== hdl/dnes_pkg.sv =====
// ----------------------------------------------------------------------------
// dnes_pkg
// Shared constants and types for the decimal number extract and sort block.
// ----------------------------------------------------------------------------
package dnes_pkg;

  localparam int MAX_NUMBERS = 32;
  localparam int IDX_W = (MAX_NUMBERS > 1) ? $clog2(MAX_NUMBERS) : 1;
  localparam int CNT_W = $clog2(MAX_NUMBERS + 1);

  localparam int VALUE_W = 64;
  localparam int PROD_W  = VALUE_W + 4;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // one stored number
  typedef struct packed {
    logic               sat;
    logic [VALUE_W-1:0] value;
  } entry_t;

  // sequencer commands to the digit accumulator
  typedef struct packed {
    logic       clear;
    logic       mul;
    logic       add;
    logic [3:0] digit;
  } acc_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_FIN,
    ST_INS_RD,
    ST_INS_CMP,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_t;

endpackage

// ===== hdl/dnes_in_if.sv =====
// ----------------------------------------------------------------------------
// dnes_in_if
// Text byte channel: valid/ready with one character per request.
// ----------------------------------------------------------------------------
interface dnes_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ===== hdl/dnes_out_if.sv =====
// ----------------------------------------------------------------------------
// dnes_out_if
// Sorted number channel: valid/ready with one number per request.
// ----------------------------------------------------------------------------
interface dnes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] sorted_value;
  logic        value_saturated;
  logic        no_numbers;
  logic        numbers_dropped;
  logic        is_last;

  modport source (output valid, output sorted_value, output value_saturated,
                  output no_numbers, output numbers_dropped, output is_last,
                  input ready);
  modport sink   (input valid, input sorted_value, input value_saturated,
                  input no_numbers, input numbers_dropped, input is_last,
                  output ready);
endinterface

// ===== hdl/decimal_number_extract_and_sort_top.sv =====
// ----------------------------------------------------------------------------
// decimal_number_extract_and_sort_top
// Reads decimal numbers out of a byte stream, keeps them in a sorted table
// and sends them out smallest first at the end of each text.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake      payload
//   in_ch     in    valid/ready    text_byte[7:0], end_of_text
//   out_ch    out   valid/ready    sorted_value[63:0], value_saturated,
//                                  no_numbers, numbers_dropped, is_last
//
// one request in flight at a time; in_ch.ready is high only when idle
// separator byte: one finish step; digit byte: times-ten, add digit, then finish
// finishing a number: a read and a compare for each table entry it moves past,
// and for the smaller or equal entry the compare stops at, set by the single table
// read port and the shared 64-bit compare; a number dropped on a full table is not stored
// output: each number is read, loaded into the output register and held until out_ch.ready
// synchronous reset clears the counts and flags; the table needs no clearing
//
module decimal_number_extract_and_sort_top
  import dnes_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  dnes_in_if.sink     in_ch,
  dnes_out_if.source  out_ch
);

  state_t state, state_next;

  // captured request
  logic [7:0] byte_r;
  logic       eot_r;
  logic       is_digit_r;

  // text state
  logic             in_number, in_number_next;
  logic [CNT_W-1:0] count, count_next;
  logic             dropped, dropped_next;
  logic [IDX_W-1:0] pos, pos_next;
  logic [IDX_W-1:0] k, k_next;

  // output register
  logic               out_valid, out_valid_next;
  logic [VALUE_W-1:0] out_value, out_value_next;
  logic               out_sat, out_sat_next;
  logic               out_none, out_none_next;
  logic               out_drop, out_drop_next;
  logic               out_last, out_last_next;

  // sorted table
  entry_t           mem [MAX_NUMBERS];
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_rdata;

  // accumulator
  acc_ctrl_t          acc_ctrl;
  logic [VALUE_W-1:0] acc_value;
  logic               acc_sat;
  entry_t             acc_entry;

  logic in_fire;
  logic in_digit;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign in_digit = (in_ch.text_byte >= CHAR_ZERO) && (in_ch.text_byte <= CHAR_NINE);
  assign acc_entry.sat   = acc_sat;
  assign acc_entry.value = acc_value;

  dnes_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (acc_ctrl),
    .acc_value (acc_value),
    .acc_sat   (acc_sat)
  );

  always_comb begin
    state_next     = state;
    in_number_next = in_number;
    count_next     = count;
    dropped_next   = dropped;
    pos_next       = pos;
    k_next         = k;
    out_valid_next = out_valid;
    out_value_next = out_value;
    out_sat_next   = out_sat;
    out_none_next  = out_none;
    out_drop_next  = out_drop;
    out_last_next  = out_last;
    mem_we         = 1'b0;
    mem_waddr      = pos;
    mem_wdata      = acc_entry;
    mem_raddr      = k;
    acc_ctrl.clear = 1'b0;
    acc_ctrl.mul   = 1'b0;
    acc_ctrl.add   = 1'b0;
    // ascii digit code minus '0' is its low nibble
    acc_ctrl.digit = byte_r[3:0];

    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_digit) begin
            // first digit of a run starts from zero
            if (!in_number) begin
              acc_ctrl.clear = 1'b1;
            end
            in_number_next = 1'b1;
            state_next     = ST_MUL;
          end else begin
            state_next = ST_FIN;
          end
        end
      end

      ST_MUL: begin
        acc_ctrl.mul = 1'b1;
        state_next   = ST_ADD;
      end

      ST_ADD: begin
        acc_ctrl.add = 1'b1;
        state_next   = ST_FIN;
      end

      ST_FIN: begin
        if (in_number && (eot_r || !is_digit_r)) begin
          // close the open run
          if (count >= CNT_W'(MAX_NUMBERS)) begin
            dropped_next   = 1'b1;
            in_number_next = 1'b0;
          end else begin
            pos_next   = count[IDX_W-1:0];
            state_next = ST_INS_RD;
          end
        end else if (eot_r) begin
          if (count == '0) begin
            out_valid_next = 1'b1;
            out_value_next = '0;
            out_sat_next   = 1'b0;
            out_none_next  = 1'b1;
            out_drop_next  = dropped;
            out_last_next  = 1'b1;
            state_next     = ST_EMIT_WAIT;
          end else begin
            k_next     = '0;
            state_next = ST_EMIT_RD;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end

      ST_INS_RD: begin
        if (pos == '0) begin
          mem_we         = 1'b1;
          count_next     = count + CNT_W'(1);
          in_number_next = 1'b0;
          state_next     = ST_FIN;
        end else begin
          mem_raddr  = pos - IDX_W'(1);
          state_next = ST_INS_CMP;
        end
      end

      ST_INS_CMP: begin
        // strict compare keeps equal values in arrival order
        if (mem_rdata.value > acc_value) begin
          mem_we     = 1'b1;
          mem_wdata  = mem_rdata;
          pos_next   = pos - IDX_W'(1);
          state_next = ST_INS_RD;
        end else begin
          mem_we         = 1'b1;
          count_next     = count + CNT_W'(1);
          in_number_next = 1'b0;
          state_next     = ST_FIN;
        end
      end

      ST_EMIT_RD: begin
        mem_raddr  = k;
        state_next = ST_EMIT_LD;
      end

      ST_EMIT_LD: begin
        out_valid_next = 1'b1;
        out_value_next = mem_rdata.value;
        out_sat_next   = mem_rdata.sat;
        out_none_next  = 1'b0;
        out_drop_next  = dropped;
        out_last_next  = (CNT_W'(k) + CNT_W'(1)) == count;
        state_next     = ST_EMIT_WAIT;
      end

      ST_EMIT_WAIT: begin
        if (out_ch.ready) begin
          out_valid_next = 1'b0;
          if (out_last) begin
            // text done, back to a clean slate
            count_next     = '0;
            dropped_next   = 1'b0;
            in_number_next = 1'b0;
            state_next     = ST_IDLE;
          end else begin
            k_next     = k + IDX_W'(1);
            state_next = ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_number <= 1'b0;
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_number <= in_number_next;
      count     <= count_next;
      dropped   <= dropped_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos       <= pos_next;
    k         <= k_next;
    out_value <= out_value_next;
    out_sat   <= out_sat_next;
    out_none  <= out_none_next;
    out_drop  <= out_drop_next;
    out_last  <= out_last_next;
    if (in_fire) begin
      byte_r     <= in_ch.text_byte;
      eot_r      <= in_ch.end_of_text;
      is_digit_r <= in_digit;
    end
  end

  // table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  assign in_ch.ready            = (state == ST_IDLE);
  assign out_ch.valid           = out_valid;
  assign out_ch.sorted_value    = out_value;
  assign out_ch.value_saturated = out_sat;
  assign out_ch.no_numbers      = out_none;
  assign out_ch.numbers_dropped = out_drop;
  assign out_ch.is_last         = out_last;

endmodule

// ===== hdl/dnes_accum.sv =====
// ----------------------------------------------------------------------------
// dnes_accum
// Saturating decimal accumulator: value times ten in one step, plus digit in
// the next.
// ----------------------------------------------------------------------------
module dnes_accum
  import dnes_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  acc_ctrl_t          ctrl,
  output logic [VALUE_W-1:0] acc_value,
  output logic               acc_sat
);

  logic [VALUE_W-1:0] acc;
  logic               sat;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  sum;

  // acc * 8 + acc * 2
  logic [PROD_W-1:0] times_ten;
  assign times_ten = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
  assign sum       = prod + {{(PROD_W-4){1'b0}}, ctrl.digit};

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      sat <= 1'b0;
    end else if (ctrl.clear) begin
      acc <= '0;
      sat <= 1'b0;
    end else if (ctrl.add && !sat) begin
      if (|sum[PROD_W-1:VALUE_W]) begin
        acc <= '1;
        sat <= 1'b1;
      end else begin
        acc <= sum[VALUE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod <= times_ten;
    end
  end

  assign acc_value = acc;
  assign acc_sat   = sat;

endmodule

// ===== test/decimal_number_extract_and_sort_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_number_extract_and_sort_checker
// Watches the text and sorted number channels, rebuilds the sorted table
// from every accepted text byte and compares each emitted number with it.
// ----------------------------------------------------------------------------
module decimal_number_extract_and_sort_checker
  import dnes_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         text_byte,
  input  logic               end_of_text,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [VALUE_W-1:0] sorted_value,
  input  logic               value_saturated,
  input  logic               no_numbers,
  input  logic               numbers_dropped,
  input  logic               is_last,
  output int unsigned        mismatch_count,
  output int unsigned        results_pending
);

  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               saturated;
    logic               none;
    logic               dropped;
    logic               last;
  } number_result_t;

  entry_t             sorted_table [MAX_NUMBERS];
  int unsigned        stored_count;
  logic [VALUE_W-1:0] run_value;
  logic               run_open;
  logic               run_clamped;
  logic               table_overflowed;
  number_result_t     awaited_numbers [$];
  int unsigned        mismatches;

  task automatic clear_text();
    stored_count     = 0;
    run_value        = '0;
    run_open         = 1'b0;
    run_clamped      = 1'b0;
    table_overflowed = 1'b0;
  endtask

  // insertion keeps equal values in arrival order
  task automatic store_number();
    int pos;
    if (stored_count >= MAX_NUMBERS) begin
      table_overflowed = 1'b1;
    end else begin
      pos = stored_count;
      while (pos > 0 && sorted_table[pos-1].value > run_value) begin
        sorted_table[pos] = sorted_table[pos-1];
        pos--;
      end
      sorted_table[pos].value = run_value;
      sorted_table[pos].sat   = run_clamped;
      stored_count++;
    end
    run_open = 1'b0;
  endtask

  task automatic take_digit(input logic [3:0] digit);
    logic [VALUE_W-1:0] d;
    d = VALUE_W'(digit);
    if (!run_open) begin
      run_value   = '0;
      run_clamped = 1'b0;
      run_open    = 1'b1;
    end
    if (!run_clamped) begin
      if (run_value > (VALUE_MAX - d) / 64'd10) begin
        run_value   = VALUE_MAX;
        run_clamped = 1'b1;
      end else begin
        run_value = run_value * 64'd10 + d;
      end
    end
  endtask

  task automatic predict_text_byte(input logic [7:0] b, input logic eot);
    number_result_t r;
    int unsigned    k;
    if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
      take_digit(4'(b - CHAR_ZERO));
    end else if (run_open) begin
      store_number();
    end
    if (eot) begin
      if (run_open) store_number();
      if (stored_count == 0) begin
        r = '{value: '0, saturated: 1'b0, none: 1'b1, dropped: table_overflowed,
              last: 1'b1};
        awaited_numbers.push_back(r);
      end else begin
        for (k = 0; k < stored_count; k++) begin
          r.value     = sorted_table[k].value;
          r.saturated = sorted_table[k].sat;
          r.none      = 1'b0;
          r.dropped   = table_overflowed;
          r.last      = (k + 1 == stored_count);
          awaited_numbers.push_back(r);
        end
      end
      clear_text();
    end
  endtask

  task automatic check_field(input string field, input logic [VALUE_W-1:0] want,
                             input logic [VALUE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    number_result_t want;
    if (rst) begin
      clear_text();
      awaited_numbers.delete();
      mismatches = 0;
    end else begin
      if (in_valid && in_ready) predict_text_byte(text_byte, end_of_text);
      if (out_valid && out_ready) begin
        if (awaited_numbers.size() == 0) begin
          $error("sorted_value: expected none, got %0d", sorted_value);
          mismatches++;
        end else begin
          want = awaited_numbers.pop_front();
          check_field("sorted_value", want.value, sorted_value);
          check_field("value_saturated", VALUE_W'(want.saturated),
                      VALUE_W'(value_saturated));
          check_field("no_numbers", VALUE_W'(want.none), VALUE_W'(no_numbers));
          check_field("numbers_dropped", VALUE_W'(want.dropped),
                      VALUE_W'(numbers_dropped));
          check_field("is_last", VALUE_W'(want.last), VALUE_W'(is_last));
        end
      end
    end
    mismatch_count  <= mismatches;
    results_pending <= awaited_numbers.size();
  end

endmodule

// ===== test/decimal_number_extract_and_sort_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_number_extract_and_sort_top_tb
// Feeds texts of digits and separators into the block, a few hand-picked
// ones first and then random ones, with random gaps on both channels, and
// lets the checker compare every sorted number against its own prediction.
// ----------------------------------------------------------------------------
module decimal_number_extract_and_sort_top_tb;
  import dnes_pkg::*;

  localparam int                 ITEM_TARGET    = 410;
  localparam int                 IDLE_PCT       = 23;
  localparam int                 STALL_CYCLES   = 400;
  // worst legal quiet spell is the long receiver stall; allow many times that
  localparam int                 WATCHDOG_LIMIT = 4000;
  localparam int                 SETTLE_CYCLES  = 150;
  localparam logic [VALUE_W-1:0] VALUE_MAX      = '1;

  logic        clk = 1'b0;
  logic        rst;
  int unsigned mismatch_count;
  int unsigned results_pending;
  int unsigned requests_sent;
  int unsigned quiet_cycles;
  logic [7:0]  text_bytes [$];
  bit          steady;      // no idling on either side while set
  bit          long_stall;  // asks the receiver for its one long hold-off

  dnes_in_if  in_ch ();
  dnes_out_if out_ch ();

  always #1 clk = ~clk;

  decimal_number_extract_and_sort_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  decimal_number_extract_and_sort_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .text_byte       (in_ch.text_byte),
    .end_of_text     (in_ch.end_of_text),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .sorted_value    (out_ch.sorted_value),
    .value_saturated (out_ch.value_saturated),
    .no_numbers      (out_ch.no_numbers),
    .numbers_dropped (out_ch.numbers_dropped),
    .is_last         (out_ch.is_last),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  // any cycle with a request on either channel restarts the count
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    bit stall_taken;
    hold_left   = 0;
    stall_taken = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (long_stall && !stall_taken) begin
        stall_taken = 1'b1;
        hold_left   = STALL_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // one byte per request; valid stays up between back-to-back requests
  task automatic send_request(input logic [7:0] b, input logic eot);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.text_byte   <= b;
    in_ch.end_of_text <= eot;
    do @(posedge clk); while (!in_ch.ready);
    requests_sent++;
  endtask

  // end_of_text rides on the final byte of the text
  task automatic send_text();
    for (int i = 0; i < text_bytes.size(); i++) begin
      send_request(text_bytes[i], i == text_bytes.size() - 1);
    end
  endtask

  // sender stops and waits until every predicted number has come out
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
  endtask

  task automatic push_chars(input string s);
    for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
  endtask

  task automatic add_separator();
    logic [7:0] b;
    case ($urandom_range(3))
      0:       b = " ";
      1:       b = $urandom_range(1) ? "-" : "+";
      2:       b = $urandom_range(1) ? 8'h00 : 8'hFF;
      default: begin
        do b = 8'($urandom_range(255)); while (b >= CHAR_ZERO && b <= CHAR_NINE);
      end
    endcase
    text_bytes.push_back(b);
  endtask

  // roll picks the kind of number: small, single digit, full 64-bit range,
  // just under the top, right at or past the top, or a very long run
  task automatic add_number(input int roll);
    logic [VALUE_W-1:0] v;
    if (roll < 85) begin
      if (roll < 45)      v = VALUE_W'($urandom_range(999));
      else if (roll < 65) v = VALUE_W'($urandom_range(9));
      else if (roll < 75) v = {$urandom, $urandom};
      else                v = VALUE_MAX - VALUE_W'($urandom_range(15));
      // leading zeros now and then
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 3)) text_bytes.push_back(CHAR_ZERO);
      end
      push_chars($sformatf("%0d", v));
    end else if (roll < 93) begin
      // last digit 5 gives exactly the top value, 6..9 clamp
      push_chars("1844674407370955161");
      text_bytes.push_back(CHAR_ZERO + 8'($urandom_range(5, 9)));
      if ($urandom_range(1)) begin
        repeat ($urandom_range(1, 3)) text_bytes.push_back(CHAR_ZERO + 8'($urandom_range(9)));
      end
    end else begin
      text_bytes.push_back(CHAR_ZERO + 8'($urandom_range(1, 9)));
      repeat (20 + $urandom_range(3)) text_bytes.push_back(CHAR_ZERO + 8'($urandom_range(9)));
    end
  endtask

  // well-formed text: numbers split by separators, the run may end on a digit
  task automatic build_text(input int numbers, input int max_roll, input int max_gap);
    text_bytes.delete();
    if ($urandom_range(1)) add_separator();
    for (int n = 0; n < numbers; n++) begin
      if (n > 0) repeat ($urandom_range(1, max_gap)) add_separator();
      add_number($urandom_range(max_roll));
    end
    if (numbers == 0 || $urandom_range(1)) add_separator();
  endtask

  initial begin : stimulus
    int text_idx;
    rst               <= 1'b1;
    steady            <= 1'b0;
    long_stall        <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.text_byte   <= '0;
    in_ch.end_of_text <= 1'b0;
    requests_sent     = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed texts
    // a lone zero byte: no numbers at all
    text_bytes = '{8'h00};
    send_text();
    // a single zero is a number, not an empty text
    text_bytes.delete();
    push_chars("0");
    send_text();
    // signs as separators, leading zero, equal values, 0xff as last byte
    text_bytes.delete();
    push_chars("7-07+3");
    text_bytes.push_back(8'hFF);
    send_text();
    // characters next to the digit range, text ends inside a number
    text_bytes.delete();
    push_chars("/:9");
    send_text();
    // only separators, one of them above the ascii range
    text_bytes = '{8'h80, " ", 8'hFF};
    send_text();
    // all zeros then a sign
    text_bytes.delete();
    push_chars("000+");
    send_text();

    // random texts
    text_idx = 0;
    while (requests_sent < ITEM_TARGET) begin
      if (text_idx == 0) begin
        // more numbers than the table holds, kept short
        build_text(MAX_NUMBERS + $urandom_range(1, 3), 64, 1);
      end else if (text_idx == 1) begin
        // top of the range and a clamped number in one text
        text_bytes.delete();
        add_number(80);
        add_separator();
        add_number(88);
        add_separator();
        add_number(95);
      end else if ($urandom_range(99) < 80) begin
        build_text($urandom_range(5), 99, 2);
      end else begin
        // noise: random bytes, a fair share of them digits
        text_bytes.delete();
        repeat ($urandom_range(1, 12)) begin
          if ($urandom_range(99) < 30) text_bytes.push_back(CHAR_ZERO + 8'($urandom_range(9)));
          else text_bytes.push_back(8'($urandom_range(255)));
        end
      end

      steady <= (text_idx >= 5 && text_idx <= 8);
      // long hold-off on the receiver while this text and the next go in
      if (text_idx == 3) long_stall <= 1'b1;
      send_text();
      if (text_idx == 2) drain_results();
      text_idx++;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/dnes_pkg.sv
hdl/dnes_in_if.sv
hdl/dnes_out_if.sv
hdl/dnes_accum.sv
hdl/decimal_number_extract_and_sort_top.sv
test/decimal_number_extract_and_sort_checker.sv
test/decimal_number_extract_and_sort_top_tb.sv
